FILE: hw/rtl/pbr_pkg.sv
`default_nettype none

package pbr_pkg;

  // Field widths of the pixel words and of the results.
  localparam int PIX_W  = 24;
  localparam int CHAN_W = 8;
  localparam int N_CHAN = 3;
  localparam int N_NB   = 4;
  localparam int FLAG_W = 4;
  localparam int TERM_W = 10;
  localparam int BASE_W = 11;
  localparam int RHS_W  = 12;

  // Packed stream widths, rounded up to whole bytes.
  localparam int IN_FIELDS_W  = 10 * PIX_W + FLAG_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = N_CHAN * RHS_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Guidance modes.
  localparam logic MODE_LAPLACE = 1'b0;
  localparam logic MODE_MIXED   = 1'b1;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [RHS_W-1:0] rhs_t;

  // Control shared by the lanes: pipeline advance and guidance mode.
  typedef struct packed {
    logic en;
    logic mode;
  } lane_ctrl_t;

  // Channel c of a packed 0xRRGGBB pixel; c = 0 is red.
  function automatic chan_t chan(input logic [PIX_W-1:0] pix, input logic [1:0] c);
    chan_t res;
    unique case (c)
      2'd0: res = pix[23:16];
      2'd1: res = pix[15:8];
      default: res = pix[7:0];
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pbr_lane.sv
`default_nettype none

// One colour channel: neighbour terms in the first stage, their sum in the second.
module pbr_lane (
  input  wire logic                clk,
  input  wire pbr_pkg::lane_ctrl_t ctrl,
  input  wire pbr_pkg::chan_t      s0,
  input  wire pbr_pkg::chan_t      d0,
  input  wire pbr_pkg::chan_t      sn [pbr_pkg::N_NB],
  input  wire pbr_pkg::chan_t      dn [pbr_pkg::N_NB],
  input  wire logic [pbr_pkg::FLAG_W-1:0] flags,
  output pbr_pkg::rhs_t            rhs
);

  pbr_pkg::term_t                      term_next [pbr_pkg::N_NB];
  pbr_pkg::term_t                      term      [pbr_pkg::N_NB];
  logic [pbr_pkg::BASE_W-1:0]          base_next;
  logic [pbr_pkg::BASE_W-1:0]          base;
  pbr_pkg::rhs_t                       rhs_next;

  // Per-neighbour guidance term plus the boundary value where outside the mask.
  always_comb begin
    for (int k = 0; k < pbr_pkg::N_NB; k++) begin
      logic signed [pbr_pkg::CHAN_W:0] ds;
      logic signed [pbr_pkg::CHAN_W:0] dd;
      logic [pbr_pkg::CHAN_W-1:0]      mag_s;
      logic [pbr_pkg::CHAN_W-1:0]      mag_d;
      logic signed [pbr_pkg::CHAN_W:0] guide;
      ds = $signed({1'b0, s0}) - $signed({1'b0, sn[k]});
      dd = $signed({1'b0, d0}) - $signed({1'b0, dn[k]});
      mag_s = ds[pbr_pkg::CHAN_W] ? pbr_pkg::CHAN_W'(-ds) : ds[pbr_pkg::CHAN_W-1:0];
      mag_d = dd[pbr_pkg::CHAN_W] ? pbr_pkg::CHAN_W'(-dd) : dd[pbr_pkg::CHAN_W-1:0];
      if (ctrl.mode == pbr_pkg::MODE_MIXED) begin
        // Ties go to the destination difference.
        guide = (mag_s > mag_d) ? ds : dd;
      end else begin
        guide = -$signed({1'b0, sn[k]});
      end
      term_next[k] = pbr_pkg::TERM_W'(guide);
      if (!flags[k]) begin
        term_next[k] = term_next[k] + $signed({2'b00, dn[k]});
      end
    end
    base_next = (ctrl.mode == pbr_pkg::MODE_LAPLACE) ? {1'b0, s0, 2'b00} : '0;
  end

  // Stage one registers.
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      term <= term_next;
      base <= base_next;
    end
  end

  // Merge the four terms with the centre base.
  always_comb begin
    rhs_next = $signed({1'b0, base});
    for (int k = 0; k < pbr_pkg::N_NB; k++) begin
      rhs_next = rhs_next + pbr_pkg::RHS_W'(term[k]);
    end
  end

  // Stage two register.
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      rhs <= rhs_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pbr_merge.sv
`default_nettype none

// Output register with a skid register behind it, so that the input side
// sees a registered ready.
module pbr_merge (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  input  wire pbr_pkg::rhs_t                  lane_rhs [pbr_pkg::N_CHAN],
  output logic                                ready,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [pbr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  logic [pbr_pkg::OUT_TDATA_W-1:0] word_in;
  logic [pbr_pkg::OUT_TDATA_W-1:0] skid;
  logic                            skid_valid;
  logic                            out_free;

  // Pack red, green, blue from the lowest bit up.
  always_comb begin
    word_in = '0;
    for (int c = 0; c < pbr_pkg::N_CHAN; c++) begin
      word_in[c*pbr_pkg::RHS_W +: pbr_pkg::RHS_W] = lane_rhs[c];
    end
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign ready    = !skid_valid;

  // Valid flags of the output and skid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= skid_valid || push;
      skid_valid    <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        m_axis_tdata <= skid;
      end else if (push) begin
        m_axis_tdata <= word_in;
      end
    end else if (push) begin
      skid <= word_in;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/poisson_blend_rhs_core.sv
`default_nettype none

// Poisson blending right-hand side. Each word carries a masked pixel with its
// four neighbours from source and destination and the inside-mask flags; the
// core returns one word with the red, green and blue right-hand sides. Three
// channel lanes work side by side through two pipeline stages, followed by the
// output register, and one word is taken every clock while s_axis_tready is
// high.
// s_axis_tready drops only while the skid register holds a word, which happens
// when the output has been stalled.
// guidance_mode is written through cfg_wr_en/cfg_wr_data; the user must write it only while the core is idle.
module poisson_blend_rhs_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wr_en,
  input  wire logic                               cfg_wr_data,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // Fields from bit 0: src_center, src_north, src_west, src_east, src_south,
  // dst_center, dst_north, dst_west, dst_east, dst_south (24 bits each),
  // inside_flags (4 bits), zero fill.
  input  wire logic [pbr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // Fields from bit 0: rhs_red, rhs_green, rhs_blue (12 bits signed each), zero fill.
  output logic [pbr_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

  logic                              guidance_mode;
  logic                              merge_ready;
  logic                              v1;
  logic                              v2;
  pbr_pkg::lane_ctrl_t               ctrl;
  logic [pbr_pkg::PIX_W-1:0]         src_pix [pbr_pkg::N_NB+1];
  logic [pbr_pkg::PIX_W-1:0]         dst_pix [pbr_pkg::N_NB+1];
  logic [pbr_pkg::FLAG_W-1:0]        inside_flags;
  pbr_pkg::rhs_t                     lane_rhs [pbr_pkg::N_CHAN];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      guidance_mode <= pbr_pkg::MODE_LAPLACE;
    end else if (cfg_wr_en) begin
      guidance_mode <= cfg_wr_data;
    end
  end

  // Unpack the input word: centre first, then north, west, east, south.
  always_comb begin
    for (int i = 0; i <= pbr_pkg::N_NB; i++) begin
      src_pix[i] = s_axis_tdata[i*pbr_pkg::PIX_W +: pbr_pkg::PIX_W];
      dst_pix[i] = s_axis_tdata[(i+pbr_pkg::N_NB+1)*pbr_pkg::PIX_W +: pbr_pkg::PIX_W];
    end
    inside_flags = s_axis_tdata[10*pbr_pkg::PIX_W +: pbr_pkg::FLAG_W];
  end

  // The whole pipeline advances whenever the output side can take a word.
  assign s_axis_tready = merge_ready;
  assign ctrl.en       = merge_ready;
  assign ctrl.mode     = guidance_mode;

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (ctrl.en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
    end
  end

  // One lane per colour channel.
  for (genvar c = 0; c < pbr_pkg::N_CHAN; c++) begin : g_lane
    pbr_pkg::chan_t sn [pbr_pkg::N_NB];
    pbr_pkg::chan_t dn [pbr_pkg::N_NB];
    for (genvar k = 0; k < pbr_pkg::N_NB; k++) begin : g_nb
      assign sn[k] = pbr_pkg::chan(src_pix[k+1], 2'(c));
      assign dn[k] = pbr_pkg::chan(dst_pix[k+1], 2'(c));
    end
    pbr_lane u_lane (
      .clk   (clk),
      .ctrl  (ctrl),
      .s0    (pbr_pkg::chan(src_pix[0], 2'(c))),
      .d0    (pbr_pkg::chan(dst_pix[0], 2'(c))),
      .sn    (sn),
      .dn    (dn),
      .flags (inside_flags),
      .rhs   (lane_rhs[c])
    );
  end

  // Output register and skid stage.
  pbr_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .push          (v2 && ctrl.en),
    .lane_rhs      (lane_rhs),
    .ready         (merge_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/pbr_checker.sv
`default_nettype none

// Port-level checks for the right-hand side core.
module pbr_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_axis_tready,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [pbr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output word valid after reset");

  // A stalled output word holds its data.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  // Input ready only drops while the output register is full.
  a_ready_low_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with an empty output register");

  // The skid register is empty again in the cycle after the output word is taken.
  a_ready_recovers: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready && m_axis_tready |=> s_axis_tready)
    else $error("input ready did not recover");

  // Fill bits above the three results stay zero.
  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[pbr_pkg::OUT_TDATA_W-1:pbr_pkg::OUT_FIELDS_W] == '0)
    else $error("output fill bits not zero");

endmodule

bind poisson_blend_rhs_core pbr_checker u_pbr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
